FILE: rtl/core/mnd_pkg.sv
`timescale 1ns / 1ps
// Package for the maximum neighbour difference unit: register map, defaults,
// neighbour codes and the position flags that travel between the pipeline stages.
// No dependencies.
package mnd_pkg;

    // Configuration register: width, reset value and register index.
    localparam int unsigned SIDE_W = 11;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd1024;
    localparam logic [0:0] REG_SIDE_LENGTH = 1'b0;

    // Defaults for the top level parameters.
    localparam int MAX_SIDE_DEF = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    // Neighbour codes, the low bits of the order key. Within one earlier pixel
    // a lower code wins a tie.
    localparam logic [1:0] CODE_LEFT = 2'd0;
    localparam logic [1:0] CODE_UR = 2'd1;
    localparam logic [1:0] CODE_UP = 2'd2;
    localparam logic [1:0] CODE_UL = 2'd3;

    // Which already seen neighbours a pixel has, and whether it ends the image.
    typedef struct packed {
        logic has_left;
        logic has_up;
        logic has_ur;
        logic last;
    } t_pos_flags;

endpackage

FILE: rtl/core/max_neighbor_difference_unit.sv
`timescale 1ns / 1ps
// Top level of the maximum neighbour difference unit: configuration register,
// handshakes and the two pipeline stages. Depends on mnd_pkg, mnd_window and mnd_best.
//
//  Channel   | Direction | Handshake             | Word
//  ----------+-----------+-----------------------+----------------------------------------
//  config    | in        | psel/penable/pwrite   | side_length at byte address 0
//  pixel     | in        | i_in_valid/o_in_ready | pixel_value
//  result    | out       | o_out_valid/i_out_ready | max_difference, larger/smaller, found
//
// One pixel word is taken every cycle while the input is not stalled. A pixel
// is registered with its window taps at the edge that takes it and then folded
// into the running best pair, and the result register is loaded when the last
// pixel of an image is folded. Reset is synchronous and active low; the line
// store needs no clearing pass. The input stalls only when the last pixel of an
// image waits on a result register that is still full and not being taken.
module max_neighbor_difference_unit #(
    parameter int MAX_SIDE = mnd_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = mnd_pkg::PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [PIXEL_BITS-1:0] i_pixel_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PIXEL_BITS-1:0] o_max_difference,
    output logic [PIXEL_BITS-1:0] o_larger_value,
    output logic [PIXEL_BITS-1:0] o_smaller_value,
    output logic                  o_found
);

    localparam int CNT_W = $clog2(MAX_SIDE);
    localparam int IDX_W = 2 * CNT_W;
    localparam int SIDE_W = mnd_pkg::SIDE_W;
    // Common width for comparing the register with the largest side.
    localparam int CMP_W = (SIDE_W > CNT_W + 1) ? SIDE_W : CNT_W + 1;

    logic [SIDE_W-1:0] r_side;
    logic              cfg_wr;
    logic [CMP_W-1:0]  side_w;
    logic [CNT_W-1:0]  side_last;
    logic              in_accept;
    logic              fold;

    logic                  s1_valid;
    mnd_pkg::t_pos_flags   s1_flags;
    logic [PIXEL_BITS-1:0] s1_cur, s1_left, s1_up, s1_ur, s1_ul;
    logic [IDX_W-1:0]      s1_idx, s1_up_idx;

    // A write to the side length restarts the image; other addresses are ignored.
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2:2] == mnd_pkg::REG_SIDE_LENGTH);
    assign pready = 1'b1;
    assign prdata = (paddr[2:2] == mnd_pkg::REG_SIDE_LENGTH) ? 32'(r_side) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= mnd_pkg::SIDE_RESET;
        end else if (cfg_wr) begin
            r_side <= pwdata[SIDE_W-1:0];
        end
    end

    // Effective side, kept as its last index: zero counts as one, and
    // anything above the largest supported side is clamped to it.
    always_comb begin
        side_w = CMP_W'(r_side);
        if (side_w == '0) begin
            side_last = '0;
        end else if (side_w > CMP_W'(MAX_SIDE)) begin
            side_last = CNT_W'(MAX_SIDE - 1);
        end else begin
            side_last = CNT_W'(side_w - CMP_W'(1));
        end
    end

    // The window stage may take a new pixel when it is empty or its current one moves on.
    assign o_in_ready = !s1_valid || fold;
    assign in_accept = i_in_valid && o_in_ready;

    mnd_window #(
        .MAX_SIDE  (MAX_SIDE),
        .PIXEL_BITS(PIXEL_BITS)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_clear    (cfg_wr),
        .i_pixel    (i_pixel_value),
        .i_side_last(side_last),
        .i_fold     (fold),
        .o_s1_valid (s1_valid),
        .o_flags    (s1_flags),
        .o_cur      (s1_cur),
        .o_left     (s1_left),
        .o_up       (s1_up),
        .o_ur       (s1_ur),
        .o_ul       (s1_ul),
        .o_idx      (s1_idx),
        .o_up_idx   (s1_up_idx)
    );

    mnd_best #(
        .PIXEL_BITS(PIXEL_BITS),
        .IDX_W     (IDX_W)
    ) u_best (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (cfg_wr),
        .i_s1_valid      (s1_valid),
        .i_flags         (s1_flags),
        .i_cur           (s1_cur),
        .i_left          (s1_left),
        .i_up            (s1_up),
        .i_ur            (s1_ur),
        .i_ul            (s1_ul),
        .i_idx           (s1_idx),
        .i_up_idx        (s1_up_idx),
        .i_out_ready     (i_out_ready),
        .o_fold          (fold),
        .o_out_valid     (o_out_valid),
        .o_max_difference(o_max_difference),
        .o_larger_value  (o_larger_value),
        .o_smaller_value (o_smaller_value),
        .o_found         (o_found)
    );

`ifndef SYNTHESIS
    // The last pixel of an image always leaves a result behind.
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fold && s1_flags.last |=> o_out_valid)
        else $error("last pixel folded without a result");

    // found is set exactly when the reported difference is non-zero.
    a_found_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_found == (o_max_difference != '0)))
        else $error("found flag disagrees with difference");

    // The reported pair is consistent with the reported difference.
    a_pair_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (PIXEL_BITS'(o_larger_value - o_smaller_value) == o_max_difference))
        else $error("reported pair does not give the difference");

    // A stage holding a pixel that is not the last one never blocks the input.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && !s1_flags.last |-> o_in_ready)
        else $error("input stalled without cause");
`endif

endmodule

FILE: rtl/core/mnd_window.sv
`timescale 1ns / 1ps
// Input stage: raster counters, line store of the previous row and five window taps.
// Depends on mnd_pkg.
module mnd_window #(
    parameter int MAX_SIDE = mnd_pkg::MAX_SIDE_DEF,
    parameter int PIXEL_BITS = mnd_pkg::PIXEL_BITS_DEF,
    localparam int CNT_W = $clog2(MAX_SIDE),
    localparam int IDX_W = 2 * CNT_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_clear,
    input  logic [PIXEL_BITS-1:0]  i_pixel,
    input  logic [CNT_W-1:0]       i_side_last,
    input  logic                   i_fold,
    output logic                   o_s1_valid,
    output mnd_pkg::t_pos_flags    o_flags,
    output logic [PIXEL_BITS-1:0]  o_cur,
    output logic [PIXEL_BITS-1:0]  o_left,
    output logic [PIXEL_BITS-1:0]  o_up,
    output logic [PIXEL_BITS-1:0]  o_ur,
    output logic [PIXEL_BITS-1:0]  o_ul,
    output logic [IDX_W-1:0]       o_idx,
    output logic [IDX_W-1:0]       o_up_idx
);

    logic [PIXEL_BITS-1:0] r_line [MAX_SIDE];

    logic [CNT_W-1:0] r_row, r_col, n_row, n_col;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_s1_valid;

    logic [PIXEL_BITS-1:0] r_pix, r_left, r_q, r_q1, r_q2;
    mnd_pkg::t_pos_flags   r_flags, n_flags;
    logic [IDX_W-1:0]      r_s1_idx, r_s1_up_idx;

    logic [CNT_W-1:0] rd_addr;
    logic [IDX_W-1:0] side_ext;
    logic             col_last;

    always_comb begin
        col_last = (r_col == i_side_last);
        side_ext = IDX_W'(i_side_last) + IDX_W'(1);

        // The upper-right neighbour is read ahead; on the last column the
        // first entry is read instead, as the next row's upper neighbour.
        rd_addr = col_last ? '0 : r_col + CNT_W'(1);

        n_flags.has_left = (r_col != '0);
        n_flags.has_up = (r_row != '0);
        n_flags.has_ur = (r_row != '0) && !col_last;
        n_flags.last = col_last && (r_row == i_side_last);

        n_idx = r_idx + IDX_W'(1);
        n_col = r_col + CNT_W'(1);
        n_row = r_row;
        if (n_flags.last) begin
            n_idx = '0;
            n_col = '0;
            n_row = '0;
        end else if (col_last) begin
            n_col = '0;
            n_row = r_row + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_idx <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_row <= '0;
                r_col <= '0;
                r_idx <= '0;
            end else if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
                r_idx <= n_idx;
            end
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (i_fold) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_line[r_col] <= i_pixel;
            r_q <= r_line[rd_addr];
            r_q1 <= r_q;
            r_q2 <= r_q1;
            r_pix <= i_pixel;
            r_left <= r_pix;
            r_flags <= n_flags;
            r_s1_idx <= r_idx;
            r_s1_up_idx <= r_idx - side_ext;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_flags = r_flags;
    assign o_cur = r_pix;
    assign o_left = r_left;
    assign o_up = r_q1;
    assign o_ur = r_q;
    assign o_ul = r_q2;
    assign o_idx = r_s1_idx;
    assign o_up_idx = r_s1_up_idx;

endmodule

FILE: rtl/core/mnd_best.sv
`timescale 1ns / 1ps
// Compare stage: neighbour differences, running best pair with order key, result register.
// Depends on mnd_pkg.
module mnd_best #(
    parameter int PIXEL_BITS = mnd_pkg::PIXEL_BITS_DEF,
    parameter int IDX_W = 20,
    localparam int KEY_W = IDX_W + 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_clear,
    input  logic                   i_s1_valid,
    input  mnd_pkg::t_pos_flags    i_flags,
    input  logic [PIXEL_BITS-1:0]  i_cur,
    input  logic [PIXEL_BITS-1:0]  i_left,
    input  logic [PIXEL_BITS-1:0]  i_up,
    input  logic [PIXEL_BITS-1:0]  i_ur,
    input  logic [PIXEL_BITS-1:0]  i_ul,
    input  logic [IDX_W-1:0]       i_idx,
    input  logic [IDX_W-1:0]       i_up_idx,
    input  logic                   i_out_ready,
    output logic                   o_fold,
    output logic                   o_out_valid,
    output logic [PIXEL_BITS-1:0]  o_max_difference,
    output logic [PIXEL_BITS-1:0]  o_larger_value,
    output logic [PIXEL_BITS-1:0]  o_smaller_value,
    output logic                   o_found
);

    logic [PIXEL_BITS-1:0] r_best_d, r_best_hi, r_best_lo;
    logic [KEY_W-1:0]      r_best_key;
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_d, r_out_hi, r_out_lo;
    logic                  r_out_found;

    // Candidates in order of rising key: upper-left, upper, upper-right, left.
    logic [PIXEL_BITS-1:0] nb [4];
    logic                  en [4];
    logic [KEY_W-1:0]      key [4];
    logic [PIXEL_BITS-1:0] hi [4];
    logic [PIXEL_BITS-1:0] lo [4];
    logic [PIXEL_BITS-1:0] dif [4];

    logic                  sel_v;
    logic [PIXEL_BITS-1:0] sel_d, sel_hi, sel_lo;
    logic [KEY_W-1:0]      sel_key;
    logic                  take;
    logic [PIXEL_BITS-1:0] n_best_d, n_best_hi, n_best_lo;
    logic [KEY_W-1:0]      n_best_key;
    logic                  fold;

    always_comb begin
        nb[0] = i_ul;
        nb[1] = i_up;
        nb[2] = i_ur;
        nb[3] = i_left;
        en[0] = i_flags.has_up && i_flags.has_left;
        en[1] = i_flags.has_up;
        en[2] = i_flags.has_ur;
        en[3] = i_flags.has_left;
        key[0] = {i_up_idx - IDX_W'(1), mnd_pkg::CODE_UL};
        key[1] = {i_up_idx, mnd_pkg::CODE_UP};
        key[2] = {i_up_idx + IDX_W'(1), mnd_pkg::CODE_UR};
        key[3] = {i_idx - IDX_W'(1), mnd_pkg::CODE_LEFT};

        for (int i = 0; i < 4; i++) begin
            hi[i] = (i_cur > nb[i]) ? i_cur : nb[i];
            lo[i] = (i_cur > nb[i]) ? nb[i] : i_cur;
            dif[i] = hi[i] - lo[i];
        end

        // Strictly greater replaces, so the earlier candidate keeps a tie.
        sel_v = 1'b0;
        sel_d = '0;
        sel_hi = '0;
        sel_lo = '0;
        sel_key = '1;
        for (int i = 0; i < 4; i++) begin
            if (en[i] && (dif[i] != '0) && (!sel_v || (dif[i] > sel_d))) begin
                sel_v = 1'b1;
                sel_d = dif[i];
                sel_hi = hi[i];
                sel_lo = lo[i];
                sel_key = key[i];
            end
        end

        take = sel_v && ((sel_d > r_best_d) ||
                         ((sel_d == r_best_d) && (sel_key < r_best_key)));
        n_best_d = take ? sel_d : r_best_d;
        n_best_hi = take ? sel_hi : r_best_hi;
        n_best_lo = take ? sel_lo : r_best_lo;
        n_best_key = take ? sel_key : r_best_key;

        fold = i_s1_valid && (!i_flags.last || !r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_d <= '0;
            r_best_hi <= '0;
            r_best_lo <= '0;
            r_best_key <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_clear || (fold && i_flags.last)) begin
                r_best_d <= '0;
                r_best_hi <= '0;
                r_best_lo <= '0;
                r_best_key <= '1;
            end else if (fold) begin
                r_best_d <= n_best_d;
                r_best_hi <= n_best_hi;
                r_best_lo <= n_best_lo;
                r_best_key <= n_best_key;
            end
            if (fold && i_flags.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fold && i_flags.last) begin
            r_out_d <= n_best_d;
            r_out_hi <= n_best_hi;
            r_out_lo <= n_best_lo;
            r_out_found <= (n_best_d != '0);
        end
    end

    assign o_fold = fold;
    assign o_out_valid = r_out_valid;
    assign o_max_difference = r_out_d;
    assign o_larger_value = r_out_hi;
    assign o_smaller_value = r_out_lo;
    assign o_found = r_out_found;

endmodule

FILE: bench/tb_max_neighbor_difference_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for max_neighbor_difference_unit: streams square images in
// raster order and compares each reported neighbour pair with a cycle-free predictor.
// Depends on mnd_pkg and the unit itself.
module tb_max_neighbor_difference_unit;

    localparam int PIX_W = mnd_pkg::PIXEL_BITS_DEF;
    localparam int SIDE_MAX = mnd_pkg::MAX_SIDE_DEF;
    // Byte address of the side length register on the configuration port.
    localparam logic [2:0] SIDE_ADDR = {mnd_pkg::REG_SIDE_LENGTH, 2'b00};
    // Cycles to let pass after the last result before reconfiguring: the unit folds a
    // pixel in the cycle after taking it unless the result register holds it back.
    localparam int SETTLE_CYCLES = 4;

    // One reported pair, as the predictor expects it on the result channel.
    typedef struct {
        logic [PIX_W-1:0] diff;
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] lo;
        logic             found;
    } t_pair_report;

    // Clock, reset and every input of the unit start at known values.
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [PIX_W-1:0] i_pixel_value = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [PIX_W-1:0] o_max_difference;
    logic [PIX_W-1:0] o_larger_value;
    logic [PIX_W-1:0] o_smaller_value;
    logic             o_found;

    max_neighbor_difference_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_pixel_value    (i_pixel_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_max_difference (o_max_difference),
        .o_larger_value   (o_larger_value),
        .o_smaller_value  (o_smaller_value),
        .o_found          (o_found)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the register, the previous row,
    // the two window taps, the raster position and the running best pair.
    // ------------------------------------------------------------------
    logic [mnd_pkg::SIDE_W-1:0] side_reg;
    logic [PIX_W-1:0]  prev_row [0:SIDE_MAX-1];
    logic [PIX_W-1:0]  left_pix;
    logic [PIX_W-1:0]  upleft_pix;
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [PIX_W-1:0]  best_diff;
    logic [PIX_W-1:0]  best_hi;
    logic [PIX_W-1:0]  best_lo;
    logic [22:0]       best_key;

    t_pair_report pending_reports[$];
    int           error_count = 0;
    int           reports_checked = 0;

    // Stimulus controls shared between the test tasks and the result sink.
    bit pixel_fast = 1'b0;
    bit sink_fast = 1'b0;
    int sink_hold = 0;
    int cur_side = SIDE_MAX;

    // A side of zero behaves as one, and anything beyond the line store as its depth.
    function automatic int unsigned side_in_use();
        if (side_reg == 0)
            return 1;
        if (side_reg > SIDE_MAX)
            return SIDE_MAX;
        return 32'(side_reg);
    endfunction

    function automatic void clear_image();
        left_pix = '0;
        upleft_pix = '0;
        col_pos = 0;
        row_pos = 0;
        best_diff = '0;
        best_hi = '0;
        best_lo = '0;
        best_key = '1;
    endfunction

    function automatic void reset_model();
        side_reg = mnd_pkg::SIDE_RESET;
        foreach (prev_row[k])
            prev_row[k] = '0;
        clear_image();
    endfunction

    // The order key ranks a pair by the raster position of its earlier pixel, and
    // within one earlier pixel by the neighbour code.
    function automatic logic [22:0] order_key(int unsigned r, int unsigned c,
                                              logic [1:0] code);
        int unsigned pos;
        pos = (r * side_in_use() + c) * 4 + code;
        return pos[22:0];
    endfunction

    // A differing pair replaces the best one if it is wider, or as wide with a lower key.
    function automatic void weigh_pair(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                       logic [22:0] key);
        logic [PIX_W-1:0] hi;
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] d;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        d = hi - lo;
        if (d != 0 && (d > best_diff || (d == best_diff && key < best_key))) begin
            best_diff = d;
            best_hi = hi;
            best_lo = lo;
            best_key = key;
        end
    endfunction

    // Folds one accepted pixel into the predictor and queues a report when the
    // pixel closes its image.
    function automatic void fold_pixel(logic [PIX_W-1:0] pix);
        int unsigned  s;
        int unsigned  r;
        int unsigned  c;
        logic [PIX_W-1:0] up;
        t_pair_report rep;
        s = side_in_use();
        r = row_pos;
        c = col_pos;
        up = '0;
        if (r >= s || c >= s) begin
            r = 0;
            c = 0;
        end
        if (c > 0)
            weigh_pair(pix, left_pix, order_key(r, c - 1, mnd_pkg::CODE_LEFT));
        if (r > 0) begin
            up = prev_row[c];
            if (c > 0)
                weigh_pair(pix, upleft_pix, order_key(r - 1, c - 1, mnd_pkg::CODE_UL));
            weigh_pair(pix, up, order_key(r - 1, c, mnd_pkg::CODE_UP));
            if (c + 1 < s)
                weigh_pair(pix, prev_row[c + 1],
                           order_key(r - 1, c + 1, mnd_pkg::CODE_UR));
        end
        prev_row[c] = pix;
        upleft_pix = up;
        left_pix = pix;
        if (r == s - 1 && c == s - 1) begin
            rep.diff = best_diff;
            rep.hi = best_hi;
            rep.lo = best_lo;
            rep.found = (best_diff != 0);
            pending_reports.push_back(rep);
            clear_image();
        end else begin
            c++;
            if (c >= s) begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side. The sink draws a stall for every word it takes; a test
    // may also ask for one long hold-off, which the sink counts down itself.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                wait_left = sink_hold;
                sink_hold = 0;
            end else if (o_out_valid && i_out_ready) begin
                wait_left = sink_fast ? 0 : $urandom_range(0, 14);
            end
            if (wait_left > 0) begin
                i_out_ready <= 1'b0;
                wait_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Every word taken on the result channel is matched against the oldest report
    // that the predictor has queued. Outputs are sampled before the edge updates them.
    always @(posedge i_clk) begin : result_check
        t_pair_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result word with no report pending: difference %0d",
                       o_max_difference);
                error_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("max_difference", want.diff, o_max_difference);
                check_field("larger_value", want.hi, o_larger_value);
                check_field("smaller_value", want.lo, o_smaller_value);
                check_field("found", want.found, o_found);
                reports_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel side and configuration port.
    // ------------------------------------------------------------------

    // Offers one pixel after a random gap and returns in the step at which it was
    // taken. Valid is left high so that back-to-back words are offered with no drop in valid.
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        int gap;
        gap = pixel_fast ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (!o_in_ready);
        fold_pixel(pix);
    endtask

    // Stops offering pixels and waits until every queued report has arrived, then
    // SETTLE_CYCLES more so that a pixel still being folded has settled.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the side length with a setup and an access cycle. The bits above the
    // register are filled at random, since the unit is to ignore them.
    task automatic write_side(input logic [mnd_pkg::SIDE_W-1:0] side);
        logic [31:0] word;
        word = $urandom();
        word[mnd_pkg::SIDE_W-1:0] = side;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SIDE_ADDR;
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        side_reg = side;
        clear_image();
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] draw_pixel(int mode);
        case (mode)
            0: return PIX_W'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? '1 : '0;
            2: return PIX_W'($urandom_range(65528, 65535));
            default: return PIX_W'($urandom());
        endcase
    endfunction

    function automatic int draw_side();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 1;
        if (pick < 16)
            return $urandom_range(2, 6);
        return $urandom_range(7, 20);
    endfunction

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // One-pixel images report at once and never find a pair; a side of zero acts as one.
    task automatic test_one_pixel_images();
        wait_for_results();
        write_side(1);
        send_pixel('0);
        send_pixel('1);
        wait_for_results();
        write_side(0);
        send_pixel(16'h5a5a);
        wait_for_results();
    endtask

    // The widest possible pair, both along a row and down a column.
    task automatic test_extreme_values();
        write_side(2);
        send_pixel('0);
        send_pixel('1);
        send_pixel('1);
        send_pixel('0);
        wait_for_results();
    endtask

    // A flat image has no differing pair.
    task automatic test_flat_image();
        send_pixel(16'h1234);
        send_pixel(16'h1234);
        send_pixel(16'h1234);
        send_pixel(16'h1234);
        wait_for_results();
    endtask

    // Several pairs share the largest difference of 40 but hold different values;
    // the one whose earlier pixel comes first must be reported.
    task automatic test_tie_order();
        write_side(3);
        send_pixel(100);
        send_pixel(60);
        send_pixel(20);
        repeat (6) send_pixel(60);
        wait_for_results();
    endtask

    // A register write discards a partial image, including at the largest side and
    // at a side beyond the line store, which the unit clips.
    task automatic test_restart_on_write();
        write_side(SIDE_MAX);
        send_pixel('1);
        send_pixel(7);
        wait_for_results();
        write_side('1);
        send_pixel(3);
        send_pixel('1);
        wait_for_results();
        write_side(2);
        send_pixel('1);
        wait_for_results();
        write_side(2);
        send_pixel(10);
        send_pixel(11);
        send_pixel(12);
        send_pixel(14);
        wait_for_results();
    endtask

    // The sink holds off for a long stretch while one-pixel images pour in without
    // gaps, so the result register fills and the unit must stall its input. Then the
    // sender pauses until everything has drained, and the same runs with side two.
    task automatic test_result_stall();
        write_side(1);
        sink_hold = 60;
        pixel_fast = 1'b1;
        repeat (24) send_pixel(draw_pixel(3));
        wait_for_results();
        write_side(2);
        sink_hold = 40;
        repeat (40) send_pixel(draw_pixel(3));
        pixel_fast = 1'b0;
        wait_for_results();
    endtask

    // Mostly whole images of small random sides with random content, some sides a
    // little larger, and now and then an image cut short by a register write.
    task automatic test_random_images();
        int sent;
        int count;
        int mode;
        bit cut_short;
        sent = 0;
        while (sent < 1200) begin
            if (sent == 0 || $urandom_range(0, 2) == 0) begin
                wait_for_results();
                cur_side = draw_side();
                write_side(cur_side);
            end
            mode = $urandom_range(0, 5);
            pixel_fast = ($urandom_range(0, 2) == 0);
            sink_fast = ($urandom_range(0, 2) == 0);
            count = cur_side * cur_side;
            cut_short = 1'b0;
            if (count > 1 && $urandom_range(0, 9) == 0) begin
                count = $urandom_range(1, count - 1);
                cut_short = 1'b1;
            end
            repeat (count) send_pixel(draw_pixel(mode));
            sent += count;
            if (cut_short) begin
                wait_for_results();
                write_side(cur_side);
            end
        end
        pixel_fast = 1'b0;
        sink_fast = 1'b0;
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests in turn, then judge the run.
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_one_pixel_images();
        test_extreme_values();
        test_flat_image();
        test_tie_order();
        test_restart_on_write();
        test_result_stall();
        test_random_images();

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // A healthy run takes a small fraction of this, even with every stall at its longest.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
